// ===== sv/hxd_pkg.sv =====
// Shared types, constants and helpers for the hex text decoder.
package hxd_pkg;

  localparam int SKIP_SLOTS_DEF  = 4;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int SKIP_PACKED     = 4;   // skip bytes held in the skip_chars register
  localparam int SKIP_SLOTS_MAX  = 8;
  localparam int USED_W          = 16;  // width of the reported counts
  localparam int QUEUE_DEPTH     = 4;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SKIP_CHARS = 2'd0,
    CFG_SKIP_COUNT = 2'd1,
    CFG_OUT_LIMIT  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_MALFORMED  = 2'd1,
    ST_INCOMPLETE = 2'd2,
    ST_FULL       = 2'd3
  } run_status_t;

  typedef struct packed {
    logic [8*SKIP_PACKED-1:0] skip_chars;
    logic [2:0]               skip_count;
    logic [15:0]              out_limit;
  } cfg_t;

  typedef struct packed {
    logic [USED_W-1:0] out_used;
    logic [USED_W-1:0] in_used;
    run_status_t       run_status;
    logic              done_res;
    logic              byte_valid;
    logic [7:0]        out_byte;
  } res_t;

  // Decode one ASCII hex digit: {is_digit, value}.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

endpackage

// ===== sv/hex_text_decoder_core.sv =====
// Top level of the hex text decoder: configuration registers and the three stages.
//
//  channel | direction | transfer on            | payload
//  --------+-----------+------------------------+-----------------------------------------
//  in_     | input     | in_tvalid & in_tready  | tdata char_in, tuser first_char, tlast last_char
//  out_    | output    | out_tvalid & out_tready| tdata byte/in_used/out_used, tuser valid/status,
//          |           |                        | tlast done_res
//  cfg_    | input     | cfg_valid & cfg_ready  | cfg_index register, cfg_data value
//
//  One character per clock while in_tready is high. The front end updates run state
//  at the transfer edge and writes any result into the queue at that same edge; the
//  output register takes it when it is empty or being read, and then raises out_tvalid.
//  rst_n is synchronous and clears run state, the queue and the output stage; the
//  configuration resets to no skip characters and an output limit of 65535.
//  in_tready drops only while the four-entry result queue is full, so a stalled
//  output side holds back the input after five pending results (four queued, one
//  held in the output register).
module hex_text_decoder_core import hxd_pkg::*; #(
  parameter int SKIP_SLOTS  = SKIP_SLOTS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,    // [7:0] char_in
  input  logic [0:0]            in_tuser,    // [0] first_char
  input  logic                  in_tlast,    // last_char
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [39:0]           out_tdata,   // [7:0] out_byte, [23:8] in_used, [39:24] out_used
  output logic [2:0]            out_tuser,   // [0] byte_valid, [2:1] run_status
  output logic                  out_tlast,   // done_res
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic take, push, pop, nonempty, full;
  res_t push_res, head_res;

  // Configuration writes land in the cfg_r register; unknown indexes drop.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SKIP_CHARS: cfg_nxt.skip_chars = cfg_data[8*SKIP_PACKED-1:0];
        CFG_SKIP_COUNT: cfg_nxt.skip_count = cfg_data[2:0];
        CFG_OUT_LIMIT:  cfg_nxt.out_limit  = cfg_data[15:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.skip_chars <= '0;
      cfg_r.skip_count <= 3'd0;
      cfg_r.out_limit  <= 16'hFFFF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Accept whenever the queue has room for a possible result.
  assign in_tready = !full;
  assign take      = in_tvalid && in_tready;

  hxd_front #(
    .SKIP_SLOTS  (SKIP_SLOTS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .take       (take),
    .char_in    (in_tdata),
    .first_char (in_tuser[0]),
    .last_char  (in_tlast),
    .push       (push),
    .push_res   (push_res)
  );

  hxd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_res (push_res),
    .pop      (pop),
    .head_res (head_res),
    .nonempty (nonempty),
    .full     (full)
  );

  hxd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .nonempty   (nonempty),
    .head_res   (head_res),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // A result without a new byte always ends the run.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast)
    else $error("result without byte does not end the run");

  // Error status only on a run-ending result.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[2:1] != ST_OK) |-> out_tlast && !out_tuser[0])
    else $error("error status on a byte or non-final result");

  // No byte means a zero byte field.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> (out_tdata[7:0] == 8'h00))
    else $error("stale byte on a result without byte");

  // A halted front end must not push a result without a new run.
  assert property (@(posedge clk) disable iff (!rst_n)
    push && push_res.done_res |=> !(push && !in_tuser[0]) || !$past(take))
    else $error("result after the run ended");

endmodule

// ===== sv/hxd_front.sv =====
// Front end: accepts characters, keeps run state and builds result records.
module hxd_front import hxd_pkg::*; #(
  parameter int SKIP_SLOTS  = SKIP_SLOTS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       take,       // a character transfer happens this cycle
  input  logic [7:0] char_in,
  input  logic       first_char,
  input  logic       last_char,
  output logic       push,
  output res_t       push_res
);

  localparam int EXT_W = COUNT_WIDTH + USED_W;

  logic [3:0]             high_nibble_r, high_nibble_nxt;
  logic                   pending_r, pending_nxt;
  logic [COUNT_WIDTH-1:0] in_cnt_r, in_cnt_nxt;
  logic [COUNT_WIDTH-1:0] out_cnt_r, out_cnt_nxt;
  logic                   halted_r, halted_nxt;

  logic [COUNT_WIDTH-1:0] in_cur, out_cur, in_inc, out_inc, in_rep, in_dec;
  logic                   pend_cur, halt_cur;
  logic [4:0]             hex;
  logic                   is_skip;
  logic [8*SKIP_SLOTS_MAX-1:0] skip_pad;
  logic                   at_limit;
  logic                   emit, emit_valid, emit_done;
  logic [7:0]             emit_byte;
  run_status_t            emit_status;
  logic [EXT_W-1:0]       in_ext, out_ext;

  // Start of run clears state ahead of the character.
  assign in_cur   = first_char ? '0 : in_cnt_r;
  assign out_cur  = first_char ? '0 : out_cnt_r;
  assign pend_cur = first_char ? 1'b0 : pending_r;
  assign halt_cur = first_char ? 1'b0 : halted_r;

  assign in_inc  = (in_cur == '1) ? in_cur : in_cur + 1'b1;
  assign out_inc = (out_cur == '1) ? out_cur : out_cur + 1'b1;
  assign in_dec  = (in_cur == '0) ? '0 : in_cur - 1'b1;

  assign hex      = hex_decode(char_in);
  assign at_limit = EXT_W'(out_cur) >= EXT_W'(cfg.out_limit);
  assign skip_pad = (8*SKIP_SLOTS_MAX)'(cfg.skip_chars);

  always_comb begin
    is_skip = 1'b0;
    for (int k = 0; k < SKIP_SLOTS; k++) begin
      if ((4'(k) < {1'b0, cfg.skip_count}) && (skip_pad[8*k +: 8] == char_in)) begin
        is_skip = 1'b1;
      end
    end
  end

  always_comb begin
    high_nibble_nxt = high_nibble_r;
    pending_nxt     = pending_r;
    in_cnt_nxt      = in_cnt_r;
    out_cnt_nxt     = out_cnt_r;
    halted_nxt      = halted_r;
    emit            = 1'b0;
    emit_valid      = 1'b0;
    emit_done       = 1'b0;
    emit_byte       = 8'h00;
    emit_status     = ST_OK;
    in_rep          = in_cur;
    if (take) begin
      pending_nxt = pend_cur;
      in_cnt_nxt  = in_cur;
      out_cnt_nxt = out_cur;
      halted_nxt  = halt_cur;
      if (first_char) high_nibble_nxt = 4'h0;
      if (!halt_cur) begin
        if (!pend_cur) begin
          if (!hex[4]) begin
            if (is_skip) begin
              in_cnt_nxt = in_inc;
              in_rep     = in_inc;
              emit       = last_char;
              emit_done  = last_char;
            end else begin
              emit        = 1'b1;
              emit_done   = 1'b1;
              emit_status = ST_MALFORMED;
            end
          end else if (last_char) begin
            emit        = 1'b1;
            emit_done   = 1'b1;
            emit_status = ST_INCOMPLETE;
          end else begin
            high_nibble_nxt = hex[3:0];
            pending_nxt     = 1'b1;
            in_cnt_nxt      = in_inc;
          end
        end else begin
          pending_nxt = 1'b0;
          if (!hex[4]) begin
            emit        = 1'b1;
            emit_done   = 1'b1;
            emit_status = ST_MALFORMED;
          end else if (at_limit) begin
            emit        = 1'b1;
            emit_done   = 1'b1;
            emit_status = ST_FULL;
            in_rep      = in_dec;
          end else begin
            out_cnt_nxt = out_inc;
            in_cnt_nxt  = in_inc;
            in_rep      = in_inc;
            emit        = 1'b1;
            emit_valid  = 1'b1;
            emit_done   = last_char;
            emit_byte   = {high_nibble_r, hex[3:0]};
          end
        end
        if (emit_done) halted_nxt = 1'b1;
      end
    end
  end

  // Clamp the counts to the reported width.
  assign in_ext  = EXT_W'(in_rep);
  assign out_ext = EXT_W'(out_cnt_nxt);

  always_comb begin
    push_res.out_byte   = emit_byte;
    push_res.byte_valid = emit_valid;
    push_res.done_res   = emit_done;
    push_res.run_status = emit_status;
    push_res.in_used    = (|in_ext[EXT_W-1:USED_W]) ? '1 : in_ext[USED_W-1:0];
    push_res.out_used   = (|out_ext[EXT_W-1:USED_W]) ? '1 : out_ext[USED_W-1:0];
  end

  assign push = take && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_nibble_r <= 4'h0;
      pending_r     <= 1'b0;
      in_cnt_r      <= '0;
      out_cnt_r     <= '0;
      halted_r      <= 1'b0;
    end else begin
      high_nibble_r <= high_nibble_nxt;
      pending_r     <= pending_nxt;
      in_cnt_r      <= in_cnt_nxt;
      out_cnt_r     <= out_cnt_nxt;
      halted_r      <= halted_nxt;
    end
  end

endmodule

// ===== sv/hxd_queue.sv =====
// Result queue between the front end and the output stage.
module hxd_queue import hxd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_res,
  input  logic pop,
  output res_t head_res,
  output logic nonempty,
  output logic full
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  res_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   level_r, level_nxt;

  assign nonempty = (level_r != '0);
  assign full     = (level_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign head_res = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    level_nxt  = level_r + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

endmodule

// ===== sv/hxd_back.sv =====
// Output stage: drains the queue into a registered result transfer.
module hxd_back import hxd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        nonempty,
  input  res_t        head_res,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  output logic [2:0]  out_tuser,
  output logic        out_tlast
);

  logic vld_r, vld_nxt;
  res_t res_r;

  assign pop     = nonempty && (!vld_r || out_tready);
  assign vld_nxt = pop ? 1'b1 : (vld_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else        vld_r <= vld_nxt;
  end

  always_ff @(posedge clk) begin
    if (pop) res_r <= head_res;
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {res_r.out_used, res_r.in_used, res_r.out_byte};
  assign out_tuser  = {res_r.run_status, res_r.byte_valid};
  assign out_tlast  = res_r.done_res;

endmodule
